FILE: sv/backface_cull_vertex_compact_core_macros.svh
// Assertion macros for the backface cull core RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef BACKFACE_CULL_VERTEX_COMPACT_CORE_MACROS_SVH
`define BACKFACE_CULL_VERTEX_COMPACT_CORE_MACROS_SVH

// same-cycle implication
`define BCVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bcvc_pkg.sv
// Package for the backface cull / vertex compaction core.
// Widths, codes and shared types; no dependencies.
package bcvc_pkg;

    localparam int SIZE_W       = 8;
    localparam int NORM_W       = 16;
    localparam int VTX_W        = 12;
    localparam int MAX_VERTICES = 4096;
    localparam int CNT_W        = 13;
    localparam int PROD_W       = 2 * NORM_W;
    localparam int DOT_W        = PROD_W + 2;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;
    localparam int REG_IDX_W    = 2;

    localparam logic [SIZE_W-1:0] TRI_SIZE = 8'd3;

    localparam logic RES_MAP = 1'b0;
    localparam logic RES_TRI = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_VIEW_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_VIEW_Z = 2'd2;

    localparam logic signed [NORM_W-1:0] VIEW_X_RST = 16'sd0;
    localparam logic signed [NORM_W-1:0] VIEW_Y_RST = 16'sd0;
    localparam logic signed [NORM_W-1:0] VIEW_Z_RST = -16'sd16384;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
    } view_t;

    typedef struct packed {
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        logic [VTX_W-1:0] c;
    } tri_t;

    typedef struct packed {
        logic mapped;
        logic [VTX_W-1:0] idx;
    } map_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

endpackage

FILE: sv/bcvc_if.sv
// Valid/ready channel interfaces for cell requests and result requests.
// Depends on bcvc_pkg.
interface bcvc_cell_if;
    logic                                valid;
    logic                                ready;
    logic [bcvc_pkg::SIZE_W-1:0]         cell_size;
    logic signed [bcvc_pkg::NORM_W-1:0]  normal_x;
    logic signed [bcvc_pkg::NORM_W-1:0]  normal_y;
    logic signed [bcvc_pkg::NORM_W-1:0]  normal_z;
    logic [bcvc_pkg::VTX_W-1:0]          src_vertex_a;
    logic [bcvc_pkg::VTX_W-1:0]          src_vertex_b;
    logic [bcvc_pkg::VTX_W-1:0]          src_vertex_c;

    modport source (
        output valid, cell_size, normal_x, normal_y, normal_z,
               src_vertex_a, src_vertex_b, src_vertex_c,
        input  ready
    );
    modport sink (
        input  valid, cell_size, normal_x, normal_y, normal_z,
               src_vertex_a, src_vertex_b, src_vertex_c,
        output ready
    );
endinterface

interface bcvc_result_if;
    logic                          valid;
    logic                          ready;
    logic                          result_type;
    logic [bcvc_pkg::VTX_W-1:0]    source_vertex;
    logic [bcvc_pkg::VTX_W-1:0]    compact_vertex;
    logic [bcvc_pkg::VTX_W-1:0]    tri_a;
    logic [bcvc_pkg::VTX_W-1:0]    tri_b;
    logic [bcvc_pkg::VTX_W-1:0]    tri_c;
    logic                          last;

    modport source (
        output valid, result_type, source_vertex, compact_vertex,
               tri_a, tri_b, tri_c, last,
        input  ready
    );
    modport sink (
        input  valid, result_type, source_vertex, compact_vertex,
               tri_a, tri_b, tri_c, last,
        output ready
    );
endinterface

FILE: sv/bcvc_front.sv
// Front end: accepts cell requests, drops non-triangles, computes the facing
// dot product and pushes kept triangles into the queue. Depends on bcvc_pkg, bcvc_if.
module bcvc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    bcvc_cell_if.sink              mesh_cell,
    input  bcvc_pkg::view_t        view,
    input  bcvc_pkg::fifo_stat_t   fifo_stat,
    input  bcvc_pkg::back_stat_t   back_stat,
    output logic                   push,
    output bcvc_pkg::tri_t         push_tri
);

    logic                                 s1_valid_reg, s1_valid_next;
    logic signed [bcvc_pkg::PROD_W-1:0]   prod_x_reg, prod_x_next;
    logic signed [bcvc_pkg::PROD_W-1:0]   prod_y_reg, prod_y_next;
    logic signed [bcvc_pkg::PROD_W-1:0]   prod_z_reg, prod_z_next;
    bcvc_pkg::tri_t                       tri_reg, tri_next;
    logic signed [bcvc_pkg::DOT_W-1:0]    dot;
    logic                                 keep;
    logic                                 s1_done;
    logic                                 accept;

    always_comb
    begin
        dot = bcvc_pkg::DOT_W'(prod_x_reg) + bcvc_pkg::DOT_W'(prod_y_reg)
            + bcvc_pkg::DOT_W'(prod_z_reg);
        keep    = !dot[bcvc_pkg::DOT_W-1];
        s1_done = !s1_valid_reg || !keep || !fifo_stat.full;
        push    = s1_valid_reg && keep && !fifo_stat.full;
        push_tri = tri_reg;
        mesh_cell.ready = s1_done && !back_stat.clearing;
        accept = mesh_cell.valid && mesh_cell.ready;

        prod_x_next = prod_x_reg;
        prod_y_next = prod_y_reg;
        prod_z_next = prod_z_reg;
        tri_next    = tri_reg;
        s1_valid_next = s1_done ? 1'b0 : s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = (mesh_cell.cell_size == bcvc_pkg::TRI_SIZE);
            prod_x_next = mesh_cell.normal_x * view.x;
            prod_y_next = mesh_cell.normal_y * view.y;
            prod_z_next = mesh_cell.normal_z * view.z;
            tri_next.a  = mesh_cell.src_vertex_a;
            tri_next.b  = mesh_cell.src_vertex_b;
            tri_next.c  = mesh_cell.src_vertex_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        tri_reg    <= tri_next;
    end

endmodule

FILE: sv/bcvc_tri_fifo.sv
// Short queue of kept triangles between the front and back ends.
// Depends on bcvc_pkg.
module bcvc_tri_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bcvc_pkg::tri_t         push_tri,
    input  logic                   pop,
    output bcvc_pkg::tri_t         head_tri,
    output bcvc_pkg::fifo_stat_t   stat
);

    bcvc_pkg::tri_t                slot_reg [bcvc_pkg::FIFO_DEPTH];
    logic [bcvc_pkg::FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bcvc_pkg::FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bcvc_pkg::FIFO_AW:0]    count_reg, count_next;

    always_comb
    begin
        stat.full  = (count_reg == (bcvc_pkg::FIFO_AW+1)'(bcvc_pkg::FIFO_DEPTH));
        stat.empty = (count_reg == '0);
        head_tri   = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tri;
        end
    end

endmodule

FILE: sv/bcvc_back.sv
// Back end: clears the remap store, looks up / assigns compact indices for
// each queued triangle and drives the result register. Depends on bcvc_pkg, bcvc_if.
`include "backface_cull_vertex_compact_core_macros.svh"

module bcvc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bcvc_pkg::tri_t         head_tri,
    input  bcvc_pkg::fifo_stat_t   fifo_stat,
    output logic                   pop,
    output bcvc_pkg::back_stat_t   back_stat,
    bcvc_result_if.source          result
);

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL, ST_TRI} state_t;

    state_t                          state_reg, state_next;
    logic [bcvc_pkg::VTX_W-1:0]      clr_cnt_reg, clr_cnt_next;
    bcvc_pkg::tri_t                  tri_reg, tri_next;
    logic [1:0]                      j_reg, j_next;
    logic                            same_reg, same_next;
    logic [bcvc_pkg::VTX_W-1:0]      prev_idx_reg, prev_idx_next;
    logic [bcvc_pkg::VTX_W-1:0]      cidx_a_reg, cidx_a_next;
    logic [bcvc_pkg::VTX_W-1:0]      cidx_b_reg, cidx_b_next;
    logic [bcvc_pkg::CNT_W-1:0]      next_idx_reg, next_idx_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_type_reg, out_type_next;
    logic [bcvc_pkg::VTX_W-1:0]      out_src_reg, out_src_next;
    logic [bcvc_pkg::VTX_W-1:0]      out_cmp_reg, out_cmp_next;
    logic [bcvc_pkg::VTX_W-1:0]      out_ta_reg, out_ta_next;
    logic [bcvc_pkg::VTX_W-1:0]      out_tb_reg, out_tb_next;
    logic [bcvc_pkg::VTX_W-1:0]      out_tc_reg, out_tc_next;
    logic                            out_last_reg, out_last_next;

    bcvc_pkg::map_entry_t            map_mem [bcvc_pkg::MAX_VERTICES];
    bcvc_pkg::map_entry_t            rd_data_reg;
    logic                            mem_we;
    logic [bcvc_pkg::VTX_W-1:0]      mem_waddr;
    bcvc_pkg::map_entry_t            mem_wdata;
    logic                            mem_re;
    logic [bcvc_pkg::VTX_W-1:0]      mem_raddr;

    logic                            out_free;
    logic                            out_load;
    logic [bcvc_pkg::VTX_W-1:0]      cur_src;
    logic [bcvc_pkg::VTX_W-1:0]      nxt_src;
    logic                            eff_mapped;
    logic [bcvc_pkg::VTX_W-1:0]      eff_idx;
    logic [bcvc_pkg::VTX_W-1:0]      resolved;

    always_comb
    begin
        out_free = !out_valid_reg || result.ready;
        back_stat.clearing = (state_reg == ST_CLEAR);

        case (j_reg)
            2'd0:    cur_src = tri_reg.a;
            2'd1:    cur_src = tri_reg.b;
            default: cur_src = tri_reg.c;
        endcase
        nxt_src = (j_reg == 2'd0) ? tri_reg.b : tri_reg.c;

        eff_mapped = same_reg || rd_data_reg.mapped;
        eff_idx    = same_reg ? prev_idx_reg : rd_data_reg.idx;
        resolved   = eff_mapped ? eff_idx : next_idx_reg[bcvc_pkg::VTX_W-1:0];

        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        tri_next      = tri_reg;
        j_next        = j_reg;
        same_next     = same_reg;
        prev_idx_next = prev_idx_reg;
        cidx_a_next   = cidx_a_reg;
        cidx_b_next   = cidx_b_reg;
        next_idx_next = next_idx_reg;

        out_valid_next = out_valid_reg && !result.ready;
        out_type_next  = out_type_reg;
        out_src_next   = out_src_reg;
        out_cmp_next   = out_cmp_reg;
        out_ta_next    = out_ta_reg;
        out_tb_next    = out_tb_reg;
        out_tc_next    = out_tc_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;

        pop       = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cur_src;
        mem_wdata = '{mapped: 1'b1, idx: next_idx_reg[bcvc_pkg::VTX_W-1:0]};
        mem_re    = 1'b0;
        mem_raddr = head_tri.a;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop        = 1'b1;
                    mem_re     = 1'b1;
                    tri_next   = head_tri;
                    j_next     = 2'd0;
                    same_next  = 1'b0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (eff_mapped || out_free)
                begin
                    if (!eff_mapped)
                    begin
                        mem_we        = 1'b1;
                        next_idx_next = next_idx_reg + 1'b1;
                        out_load      = 1'b1;
                        out_valid_next = 1'b1;
                        out_type_next = bcvc_pkg::RES_MAP;
                        out_src_next  = cur_src;
                        out_cmp_next  = resolved;
                        out_ta_next   = '0;
                        out_tb_next   = '0;
                        out_tc_next   = '0;
                        out_last_next = 1'b0;
                    end
                    prev_idx_next = resolved;
                    if (j_reg == 2'd0)
                    begin
                        cidx_a_next = resolved;
                    end
                    if (j_reg == 2'd1)
                    begin
                        cidx_b_next = resolved;
                    end
                    if (j_reg == 2'd2)
                    begin
                        state_next = ST_TRI;
                    end
                    else
                    begin
                        j_next    = j_reg + 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = nxt_src;
                        same_next = (nxt_src == cur_src);
                    end
                end
            end
            ST_TRI:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_type_next  = bcvc_pkg::RES_TRI;
                    out_src_next   = '0;
                    out_cmp_next   = '0;
                    out_ta_next    = cidx_a_reg;
                    out_tb_next    = cidx_b_reg;
                    out_tc_next    = prev_idx_reg;
                    out_last_next  = 1'b1;
                    if (!fifo_stat.empty)
                    begin
                        pop        = 1'b1;
                        mem_re     = 1'b1;
                        tri_next   = head_tri;
                        j_next     = 2'd0;
                        same_next  = 1'b0;
                        state_next = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            tri_reg       <= '0;
            j_reg         <= '0;
            same_reg      <= 1'b0;
            prev_idx_reg  <= '0;
            cidx_a_reg    <= '0;
            cidx_b_reg    <= '0;
            next_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_type_reg  <= 1'b0;
            out_src_reg   <= '0;
            out_cmp_reg   <= '0;
            out_ta_reg    <= '0;
            out_tb_reg    <= '0;
            out_tc_reg    <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tri_reg       <= tri_next;
            j_reg         <= j_next;
            same_reg      <= same_next;
            prev_idx_reg  <= prev_idx_next;
            cidx_a_reg    <= cidx_a_next;
            cidx_b_reg    <= cidx_b_next;
            next_idx_reg  <= next_idx_next;
            out_valid_reg <= out_valid_next;
            out_type_reg  <= out_type_next;
            out_src_reg   <= out_src_next;
            out_cmp_reg   <= out_cmp_next;
            out_ta_reg    <= out_ta_next;
            out_tb_reg    <= out_tb_next;
            out_tc_reg    <= out_tc_next;
            out_last_reg  <= out_last_next;
        end
    end

    // remap store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_type    = out_type_reg;
    assign result.source_vertex  = out_src_reg;
    assign result.compact_vertex = out_cmp_reg;
    assign result.tri_a          = out_ta_reg;
    assign result.tri_b          = out_tb_reg;
    assign result.tri_c          = out_tc_reg;
    assign result.last           = out_last_reg;

    `BCVC_ASSERT_NOW(a_load_free, out_load, !out_valid_reg || result.ready, "result overwritten")
    `BCVC_ASSERT_NOW(a_no_pop_clear, state_reg == ST_CLEAR, !pop && !out_valid_reg, "busy in clear")
    `BCVC_ASSERT_NOW(a_idx_bound, 1'b1, next_idx_reg <= bcvc_pkg::CNT_W'(bcvc_pkg::MAX_VERTICES), "index overflow")
    `BCVC_ASSERT_NEXT(a_map_then_eval, out_load && out_type_next == bcvc_pkg::RES_MAP, state_reg == ST_EVAL || state_reg == ST_TRI, "mapping without triangle")

endmodule

FILE: sv/backface_cull_vertex_compact_core.sv
// Top level of the backface cull / vertex compaction core: APB view registers,
// front end, triangle queue, back end. Depends on bcvc_pkg, bcvc_if and submodules.
//
//  channel     dir   handshake      carries
//  mesh_cell   in    valid/ready    cell size, face normal, three source vertices
//  result      out   valid/ready    vertex mapping or remapped triangle, last flag
//  apb         in    psel/penable   view_x, view_y, view_z (Q1.14)
//
// Front end takes one cell request per cycle unless a kept triangle waits on a full
// queue or during clearing; products are registered and the kept triangle is pushed
// from that register into the 4-entry queue. Back end does three remap-store lookups
// per kept triangle on its single read port plus the triangle result; a new-vertex
// result waits only on a stalled result register. Dropped and culled cells cost
// nothing there. After reset all 4096 store entries clear with mesh_cell.ready low.
module backface_cull_vertex_compact_core (
    input  logic                         clk,
    input  logic                         rst_n,
    bcvc_cell_if.sink                    mesh_cell,
    bcvc_result_if.source                result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcvc_pkg::APB_AW-1:0]  paddr,
    input  logic [bcvc_pkg::APB_DW-1:0]  pwdata,
    output logic [bcvc_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    logic signed [bcvc_pkg::NORM_W-1:0]  view_x_reg, view_x_next;
    logic signed [bcvc_pkg::NORM_W-1:0]  view_y_reg, view_y_next;
    logic signed [bcvc_pkg::NORM_W-1:0]  view_z_reg, view_z_next;
    logic [bcvc_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                                wr_en;
    bcvc_pkg::view_t                     view;
    bcvc_pkg::fifo_stat_t                fifo_stat;
    bcvc_pkg::back_stat_t                back_stat;
    bcvc_pkg::tri_t                      push_tri;
    bcvc_pkg::tri_t                      head_tri;
    logic                                push;
    logic                                pop;

    always_comb
    begin
        pready  = 1'b1;
        reg_idx = paddr[bcvc_pkg::APB_AW-1:2];
        wr_en   = psel && penable && pwrite && pready;
        view_x_next = view_x_reg;
        view_y_next = view_y_reg;
        view_z_next = view_z_reg;
        if (wr_en)
        begin
            case (reg_idx)
                bcvc_pkg::REG_VIEW_X: view_x_next = pwdata[bcvc_pkg::NORM_W-1:0];
                bcvc_pkg::REG_VIEW_Y: view_y_next = pwdata[bcvc_pkg::NORM_W-1:0];
                bcvc_pkg::REG_VIEW_Z: view_z_next = pwdata[bcvc_pkg::NORM_W-1:0];
                default:              view_x_next = view_x_reg;
            endcase
        end
        case (reg_idx)
            bcvc_pkg::REG_VIEW_X: prdata = bcvc_pkg::APB_DW'(view_x_reg);
            bcvc_pkg::REG_VIEW_Y: prdata = bcvc_pkg::APB_DW'(view_y_reg);
            bcvc_pkg::REG_VIEW_Z: prdata = bcvc_pkg::APB_DW'(view_z_reg);
            default:              prdata = '0;
        endcase
        view.x = view_x_reg;
        view.y = view_y_reg;
        view.z = view_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg <= bcvc_pkg::VIEW_X_RST;
            view_y_reg <= bcvc_pkg::VIEW_Y_RST;
            view_z_reg <= bcvc_pkg::VIEW_Z_RST;
        end
        else
        begin
            view_x_reg <= view_x_next;
            view_y_reg <= view_y_next;
            view_z_reg <= view_z_next;
        end
    end

    bcvc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mesh_cell (mesh_cell),
        .view      (view),
        .fifo_stat (fifo_stat),
        .back_stat (back_stat),
        .push      (push),
        .push_tri  (push_tri)
    );

    bcvc_tri_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tri (push_tri),
        .pop      (pop),
        .head_tri (head_tri),
        .stat     (fifo_stat)
    );

    bcvc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_tri  (head_tri),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .back_stat (back_stat),
        .result    (result)
    );

endmodule

FILE: test/backface_cull_vertex_compact_core_tb.sv
// Self-checking testbench for backface_cull_vertex_compact_core: directed table, then random
// mesh cells over several view settings, each result checked against an in-bench predictor or expected table values.
// Depends on bcvc_pkg, bcvc_if and the core RTL.
module backface_cull_vertex_compact_core_tb;
    import bcvc_pkg::*;

    localparam int N_DIRECTED      = 14;
    localparam int CELLS_PER_PHASE = 66;
    localparam int N_PHASES        = 6;
    localparam int SETTLE_CYCLES   = 24;
    localparam int STALL_LIMIT     = 20000;
    localparam int MAX_REPORTS     = 40;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_FRESH} row_exp_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        size;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [VTX_W-1:0]         a;
        logic [VTX_W-1:0]         b;
        logic [VTX_W-1:0]         c;
    } cell_req_t;

    typedef struct packed {
        cell_req_t        req;
        row_exp_t         how;
        logic [VTX_W-1:0] base;
    } cell_row_t;

    typedef struct packed {
        logic             kind;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] cmp;
        logic [VTX_W-1:0] ta;
        logic [VTX_W-1:0] tb;
        logic [VTX_W-1:0] tc;
        logic             last;
    } remap_res_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    bcvc_cell_if   cell_ch();
    bcvc_result_if res_ch();

    backface_cull_vertex_compact_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mesh_cell (cell_ch),
        .result    (res_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predictor state
    view_t            cur_view = '{VIEW_X_RST, VIEW_Y_RST, VIEW_Z_RST};
    bit               map_seen [MAX_VERTICES];
    logic [VTX_W-1:0] map_idx [MAX_VERTICES];
    int unsigned      next_compact = 0;

    remap_res_t       pending_remaps[$];
    logic [VTX_W-1:0] vertex_pool[$];

    bit          idle_on = 1'b1;
    int unsigned n_errors = 0;
    int unsigned n_cells = 0;
    int unsigned n_kept = 0;
    int unsigned n_culled = 0;
    int unsigned n_dropped = 0;
    int unsigned n_results = 0;
    int unsigned quiet_cycles = 0;

    // reset view: kept iff nz <= 0
    cell_row_t dir_rows [N_DIRECTED] = '{
        '{'{8'd3,   16'sd0,      16'sd0,      -16'sd16384, 12'd0,    12'd4095, 12'd2048},
          EXP_FRESH, 12'd0},
        '{'{8'd0,   16'sd0,      16'sd0,      -16'sd16384, 12'd1,    12'd2,    12'd3},
          EXP_NONE,  12'd0},
        '{'{8'd255, 16'sd0,      16'sd0,      -16'sd16384, 12'd1,    12'd2,    12'd3},
          EXP_NONE,  12'd0},
        '{'{8'd2,   16'sd0,      16'sd0,      -16'sd16384, 12'd1,    12'd2,    12'd3},
          EXP_NONE,  12'd0},
        '{'{8'd4,   16'sd0,      16'sd0,      -16'sd16384, 12'd1,    12'd2,    12'd3},
          EXP_NONE,  12'd0},
        '{'{8'd3,   16'sd0,      16'sd0,      16'sd16384,  12'd11,   12'd12,   12'd13},
          EXP_NONE,  12'd0},
        '{'{8'd3,   16'sd0,      16'sd0,      16'sd1,      12'd14,   12'd15,   12'd16},
          EXP_NONE,  12'd0},
        '{'{8'd3,   16'sd16384,  -16'sd16384, 16'sd0,      12'd0,    12'd4095, 12'd5},
          EXP_PRED,  12'd0},
        '{'{8'd3,   16'sd0,      16'sd0,      -16'sd1,     12'd7,    12'd7,    12'd7},
          EXP_PRED,  12'd0},
        '{'{8'd3,   16'sd0,      16'sd0,      -16'sd16384, 12'd9,    12'd10,   12'd9},
          EXP_PRED,  12'd0},
        '{'{8'd3,   16'sd0,      16'sd0,      -16'sd16384, 12'd0,    12'd4095, 12'd2048},
          EXP_PRED,  12'd0},
        '{'{8'd3,   -16'sd16384, 16'sd16384,  -16'sd16384, 12'hAAA,  12'h555,  12'hFFF},
          EXP_PRED,  12'd0},
        '{'{8'd3,   16'sh7FFF,   16'sh8000,   16'sh8000,   12'h800,  12'h7FF,  12'h001},
          EXP_PRED,  12'd0},
        '{'{8'd3,   16'sd0,      16'sd0,      16'sd0,      12'h100,  12'h200,  12'h300},
          EXP_PRED,  12'd0}
    };

    view_t view_plan [4] = '{
        '{16'sd16384,  16'sd0,      16'sd0},
        '{-16'sd16384, -16'sd16384, 16'sd16384},
        '{16'sd0,      16'sd0,      16'sd0},
        '{16'sd0,      16'sd16384,  -16'sd16384}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void cull_and_remap(input cell_req_t c, output remap_res_t outs[4],
                                           output int n_out);
        longint           dot;
        logic [VTX_W-1:0] vtx [3];
        logic [VTX_W-1:0] cidx [3];
        n_out = 0;
        outs = '{default: '0};
        if (c.size != TRI_SIZE)
        begin
            n_dropped++;
            return;
        end
        dot = longint'(c.nx) * longint'(cur_view.x) + longint'(c.ny) * longint'(cur_view.y)
            + longint'(c.nz) * longint'(cur_view.z);
        if (dot < 0)
        begin
            n_culled++;
            return;
        end
        n_kept++;
        vtx = '{c.a, c.b, c.c};
        for (int j = 0; j < 3; j++)
        begin
            if (!map_seen[vtx[j]])
            begin
                map_seen[vtx[j]] = 1'b1;
                map_idx[vtx[j]] = VTX_W'(next_compact);
                next_compact++;
                outs[n_out] = '{RES_MAP, vtx[j], map_idx[vtx[j]], 12'd0, 12'd0, 12'd0, 1'b0};
                n_out++;
            end
            cidx[j] = map_idx[vtx[j]];
        end
        outs[n_out] = '{RES_TRI, 12'd0, 12'd0, cidx[0], cidx[1], cidx[2], 1'b1};
        n_out++;
    endfunction

    function automatic logic [VTX_W-1:0] pick_vertex();
        logic [VTX_W-1:0] v;
        if (vertex_pool.size() == 0 || $urandom_range(2) == 0)
        begin
            v = VTX_W'($urandom_range(MAX_VERTICES - 1));
            vertex_pool.push_back(v);
        end
        else
        begin
            v = vertex_pool[$urandom_range(vertex_pool.size() - 1)];
        end
        return v;
    endfunction

    function automatic logic signed [NORM_W-1:0] pick_q14();
        if ($urandom_range(9) == 0)
            return NORM_W'($urandom);
        return NORM_W'(int'($urandom_range(32768)) - 16384);
    endfunction

    task automatic send_cell(input cell_req_t c);
        while (idle_on && $urandom_range(99) < 23)
        begin
            cell_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cell_ch.valid        <= 1'b1;
        cell_ch.cell_size    <= c.size;
        cell_ch.normal_x     <= c.nx;
        cell_ch.normal_y     <= c.ny;
        cell_ch.normal_z     <= c.nz;
        cell_ch.src_vertex_a <= c.a;
        cell_ch.src_vertex_b <= c.b;
        cell_ch.src_vertex_c <= c.c;
        @(posedge clk);
        while (!cell_ch.ready)
            @(posedge clk);
        n_cells++;
    endtask

    task automatic write_view_reg(input logic [REG_IDX_W-1:0] idx,
                                  input logic signed [NORM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW - NORM_W){value[NORM_W-1]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_VIEW_X: cur_view.x = value;
            REG_VIEW_Y: cur_view.y = value;
            REG_VIEW_Z: cur_view.z = value;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        cell_ch.valid <= 1'b0;
        while (pending_remaps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        res_ch.ready <= !idle_on || ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        remap_res_t got;
        remap_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.result_type, res_ch.source_vertex, res_ch.compact_vertex,
                    res_ch.tri_a, res_ch.tri_b, res_ch.tri_c, res_ch.last};
            n_results++;
            if (pending_remaps.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result expected none got %h", $time, got);
            end
            else
            begin
                want = pending_remaps.pop_front();
                check_field("result_type", want.kind, got.kind);
                check_field("source_vertex", want.src, got.src);
                check_field("compact_vertex", want.cmp, got.cmp);
                check_field("tri_a", want.ta, got.ta);
                check_field("tri_b", want.tb, got.tb);
                check_field("tri_c", want.tc, got.tc);
                check_field("last", want.last, got.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cell_ch.valid && cell_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        cell_req_t  c;
        remap_res_t outs [4];
        int         n_out;
        view_t      v;
        logic [VTX_W-1:0] base;

        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        cell_ch.valid        <= 1'b0;
        cell_ch.cell_size    <= '0;
        cell_ch.normal_x     <= '0;
        cell_ch.normal_y     <= '0;
        cell_ch.normal_z     <= '0;
        cell_ch.src_vertex_a <= '0;
        cell_ch.src_vertex_b <= '0;
        cell_ch.src_vertex_c <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            c = dir_rows[i].req;
            send_cell(c);
            cull_and_remap(c, outs, n_out);
            base = dir_rows[i].base;
            case (dir_rows[i].how)
                EXP_PRED:
                    for (int k = 0; k < n_out; k++)
                        pending_remaps.push_back(outs[k]);
                EXP_FRESH:
                begin
                    pending_remaps.push_back('{RES_MAP, c.a, base, 12'd0, 12'd0, 12'd0, 1'b0});
                    pending_remaps.push_back('{RES_MAP, c.b, base + 12'd1, 12'd0, 12'd0, 12'd0,
                                               1'b0});
                    pending_remaps.push_back('{RES_MAP, c.c, base + 12'd2, 12'd0, 12'd0, 12'd0,
                                               1'b0});
                    pending_remaps.push_back('{RES_TRI, 12'd0, 12'd0, base, base + 12'd1,
                                               base + 12'd2, 1'b1});
                end
                default: ;
            endcase
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            if (p < 4)
                v = view_plan[p];
            else
                v = '{pick_q14(), pick_q14(), pick_q14()};
            write_view_reg(REG_VIEW_X, v.x);
            write_view_reg(REG_VIEW_Y, v.y);
            write_view_reg(REG_VIEW_Z, v.z);
            // spare address must leave the view untouched
            if (p == 0)
                write_view_reg(REG_SPARE, 16'sh8001);
            idle_on = (p != 2);
            for (int i = 0; i < CELLS_PER_PHASE; i++)
            begin
                c.size = ($urandom_range(99) < 88) ? TRI_SIZE : SIZE_W'($urandom_range(255));
                c.nx = pick_q14();
                c.ny = pick_q14();
                c.nz = pick_q14();
                c.a  = pick_vertex();
                c.b  = pick_vertex();
                c.c  = pick_vertex();
                send_cell(c);
                cull_and_remap(c, outs, n_out);
                for (int k = 0; k < n_out; k++)
                    pending_remaps.push_back(outs[k]);
            end
        end
        drain_results();

        $display("Covered %0d cells: %0d kept, %0d culled, %0d not triangles; %0d views.",
                 n_cells, n_kept, n_culled, n_dropped, N_PHASES + 1);
        $display("Checked %0d results, %0d compact vertices assigned.", n_results, next_compact);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
